FILE: design/assert_macros.svh
// Assertion macros used by the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define M2U_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define M2U_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: design/m2u_pkg.sv
// Package with the SHA-1 constants and types of the MAC to UUID-E hasher.
package m2u_pkg;

  localparam int M2U_ROUNDS = 80;
  localparam int M2U_WIN_WORDS = 16;

  localparam logic [31:0] M2U_H0 = 32'h6745_2301;
  localparam logic [31:0] M2U_H1 = 32'hEFCD_AB89;
  localparam logic [31:0] M2U_H2 = 32'h98BA_DCFE;
  localparam logic [31:0] M2U_H3 = 32'h1032_5476;
  localparam logic [31:0] M2U_H4 = 32'hC3D2_E1F0;

  localparam logic [31:0] M2U_NS_W0 = 32'h5264_80F8;
  localparam logic [31:0] M2U_NS_W1 = 32'hC99B_4BE5;
  localparam logic [31:0] M2U_NS_W2 = 32'hA655_58ED;
  localparam logic [31:0] M2U_NS_W3 = 32'h5F5D_6084;

  localparam logic [15:0] M2U_PAD_HALF = 16'h8000;
  localparam logic [31:0] M2U_MSG_BITS = 32'd176;

  localparam logic [3:0] M2U_VERSION = 4'h5;
  localparam logic [1:0] M2U_VARIANT = 2'b10;

  typedef enum logic [1:0] {
    M2U_F_CH,
    M2U_F_PARITY,
    M2U_F_MAJ
  } m2u_func_e;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
    logic [M2U_WIN_WORDS-1:0][31:0] w;
  } m2u_work_t;

  function automatic m2u_func_e m2u_func(input int round);
    m2u_func_e fn;
    if (round < 20) begin
      fn = M2U_F_CH;
    end else if (round < 40) begin
      fn = M2U_F_PARITY;
    end else if (round < 60) begin
      fn = M2U_F_MAJ;
    end else begin
      fn = M2U_F_PARITY;
    end
    return fn;
  endfunction

  function automatic logic [31:0] m2u_k(input int round);
    logic [31:0] k;
    if (round < 20) begin
      k = 32'h5A82_7999;
    end else if (round < 40) begin
      k = 32'h6ED9_EBA1;
    end else if (round < 60) begin
      k = 32'h8F1B_BCDC;
    end else begin
      k = 32'hCA62_C1D6;
    end
    return k;
  endfunction

endpackage

FILE: design/m2u_round.sv
// One registered SHA-1 round stage with its rolling message schedule window.
module m2u_round #(
  parameter int ROUND = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  m2u_pkg::m2u_work_t  work_i,
  output logic                valid_o,
  output m2u_pkg::m2u_work_t  work_o
);
  import m2u_pkg::*;

  localparam m2u_func_e FuncSel = m2u_func(ROUND);
  localparam logic [31:0] KConst = m2u_k(ROUND);

  logic               valid_q;
  m2u_work_t          work_q;
  m2u_work_t          work_d;
  logic [31:0]        f;
  logic [31:0]        w_new;

  always_comb begin
    case (FuncSel)
      M2U_F_CH:     f = (work_i.b & work_i.c) | (~work_i.b & work_i.d);
      M2U_F_PARITY: f = work_i.b ^ work_i.c ^ work_i.d;
      M2U_F_MAJ:    f = (work_i.b & work_i.c) | (work_i.b & work_i.d) |
                        (work_i.c & work_i.d);
      default:      f = work_i.b ^ work_i.c ^ work_i.d;
    endcase
  end

  assign w_new = work_i.w[13] ^ work_i.w[8] ^ work_i.w[2] ^ work_i.w[0];

  always_comb begin
    work_d.a = {work_i.a[26:0], work_i.a[31:27]} + f + work_i.e + KConst + work_i.w[0];
    work_d.b = work_i.a;
    work_d.c = {work_i.b[1:0], work_i.b[31:2]};
    work_d.d = work_i.c;
    work_d.e = work_i.d;
    work_d.w[M2U_WIN_WORDS-2:0] = work_i.w[M2U_WIN_WORDS-1:1];
    work_d.w[M2U_WIN_WORDS-1] = {w_new[30:0], w_new[31]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      work_q <= work_d;
    end
  end

  assign valid_o = valid_q;
  assign work_o  = work_q;

endmodule

FILE: design/m2u_out.sv
// Final digest add, UUID-E formatting, output register and skid entry.
module m2u_out (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  m2u_pkg::m2u_work_t  work_i,
  output logic                skid_full_o,
  output logic [63:0]         uuid_upper_o,
  output logic [63:0]         uuid_lower_o,
  output logic                valid_o,
  input  logic                stall_i
);
  import m2u_pkg::*;

  logic         pipe_valid;
  logic [127:0] uuid;
  logic         out_valid_q, out_valid_d;
  logic [127:0] out_data_q, out_data_d;
  logic         skid_valid_q, skid_valid_d;
  logic [127:0] skid_data_q, skid_data_d;
  logic [31:0]  h0, h1, h2, h3;
  logic         take;

  assign pipe_valid = valid_i && !skid_valid_q;

  always_comb begin
    h0 = M2U_H0 + work_i.a;
    h1 = M2U_H1 + work_i.b;
    h2 = M2U_H2 + work_i.c;
    h3 = M2U_H3 + work_i.d;
    uuid = {h0, h1, h2, h3};
    uuid[79:76] = M2U_VERSION;
    uuid[63:62] = M2U_VARIANT;
  end

  assign take = !out_valid_q || !stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (take) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = pipe_valid;
        out_data_d  = uuid;
      end
    end else if (pipe_valid) begin
      skid_valid_d = 1'b1;
      skid_data_d  = uuid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign skid_full_o  = skid_valid_q;
  assign valid_o      = out_valid_q;
  assign uuid_upper_o = out_data_q[127:64];
  assign uuid_lower_o = out_data_q[63:0];

endmodule

FILE: design/mac_to_uuid_v5_sha1_top.sv
// Top level of the MAC address to UUID-E (SHA-1 name-based, version 5) hasher.
// A result passes through the 80 round stages and the output register before it shows on the outputs.
// One item is accepted per cycle while stall_o is low, with one SHA-1 round in each of the 80 round stages.
// A stalled output fills a one-item skid entry; stall_o is high while it is full.
// Reset clears all valid bits and the skid entry; data registers are not reset.
module mac_to_uuid_v5_sha1_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [47:0] mac_address_i,
  input  logic        valid_i,
  output logic        stall_o,
  output logic [63:0] uuid_upper_o,
  output logic [63:0] uuid_lower_o,
  output logic        valid_o,
  input  logic        stall_i
);
  import m2u_pkg::*;

  logic      en;
  logic      skid_full;
  logic      valid_pipe [M2U_ROUNDS+1];
  m2u_work_t work_pipe  [M2U_ROUNDS+1];

  assign en      = !skid_full;
  assign stall_o = skid_full;

  always_comb begin
    work_pipe[0].a = M2U_H0;
    work_pipe[0].b = M2U_H1;
    work_pipe[0].c = M2U_H2;
    work_pipe[0].d = M2U_H3;
    work_pipe[0].e = M2U_H4;
    work_pipe[0].w = '0;
    work_pipe[0].w[0] = M2U_NS_W0;
    work_pipe[0].w[1] = M2U_NS_W1;
    work_pipe[0].w[2] = M2U_NS_W2;
    work_pipe[0].w[3] = M2U_NS_W3;
    work_pipe[0].w[4] = mac_address_i[47:16];
    work_pipe[0].w[5] = {mac_address_i[15:0], M2U_PAD_HALF};
    work_pipe[0].w[15] = M2U_MSG_BITS;
  end

  assign valid_pipe[0] = valid_i;

  for (genvar r = 0; r < M2U_ROUNDS; r++) begin : g_round
    m2u_round #(
      .ROUND(r)
    ) u_round (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(valid_pipe[r]),
      .work_i (work_pipe[r]),
      .valid_o(valid_pipe[r+1]),
      .work_o (work_pipe[r+1])
    );
  end

  m2u_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (valid_pipe[M2U_ROUNDS]),
    .work_i      (work_pipe[M2U_ROUNDS]),
    .skid_full_o (skid_full),
    .uuid_upper_o(uuid_upper_o),
    .uuid_lower_o(uuid_lower_o),
    .valid_o     (valid_o),
    .stall_i     (stall_i)
  );

endmodule

FILE: design/m2u_checker.sv
// Port-level checker for the MAC to UUID-E hasher and its bind to the top level.
`include "assert_macros.svh"

module m2u_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        stall_o,
  input logic [63:0] uuid_upper_o,
  input logic [63:0] uuid_lower_o,
  input logic        valid_o,
  input logic        stall_i
);

  `M2U_ASSERT_ALWAYS(a_reset_clear, !rst_ni |-> (!valid_o && !stall_o), "outputs not idle in reset")
  `M2U_ASSERT(a_out_hold, (valid_o && stall_i) |=> (valid_o && $stable(uuid_upper_o) && $stable(uuid_lower_o)), "stalled item changed")
  `M2U_ASSERT(a_version, valid_o |-> (uuid_upper_o[15:12] == 4'h5), "version nibble is not 5")
  `M2U_ASSERT(a_variant, valid_o |-> (uuid_lower_o[63:62] == 2'b10), "variant bits are not 10")
  `M2U_ASSERT(a_stall_full, stall_o |-> valid_o, "input stalled with an empty output")

endmodule

bind mac_to_uuid_v5_sha1_top m2u_checker u_checker (.*);
